/* rtl/motor_speed_controller_assert.svh */
`ifndef MOTOR_SPEED_CONTROLLER_ASSERT_SVH
`define MOTOR_SPEED_CONTROLLER_ASSERT_SVH

// condition holds at every edge out of reset
`define MSC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies the consequent at the same edge
`define MSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent at one edge implies the consequent at the next edge
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/msc_pkg.sv */
package msc_pkg;

   localparam int REF_W     = 9;
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 16;
   localparam int PROD_W    = 25;
   localparam int MAG_W     = 23;
   localparam int RECIP_W   = 24;
   localparam int RECIP_SH  = 27;
   localparam int QUOT_W    = 20;
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((64'd1 << RECIP_SH) / 10 + 1);
   localparam int DIV_STEPS = 9;
   localparam int PC_W      = 4;

   localparam logic [BYTE_W-1:0] MASK_1 = 8'h55;
   localparam logic [BYTE_W-1:0] MASK_2 = 8'h33;
   localparam logic [BYTE_W-1:0] MASK_4 = 8'h0f;
   localparam logic [BYTE_W-1:0] DAC_MAX = 8'hFF;

   typedef enum logic [1:0] {
      CSR_SPEED_REFERENCE     = 2'd0,
      CSR_PROPORTIONAL_GAIN   = 2'd1,
      CSR_FEEDFORWARD_DIVIDER = 2'd2,
      CSR_DAC_OFFSET          = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_MUL,
      OP_ABS,
      OP_RECIP,
      OP_PROP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SUM,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_LOOP_DIV,
      COND_DELIVER
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   localparam logic [PC_W-1:0] PC_START  = 4'd0;
   localparam logic [PC_W-1:0] PC_DIV    = 4'd6;
   localparam logic [PC_W-1:0] PC_LAST   = 4'd8;

   function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = ((b >> 1) & MASK_1) | ((b << 1) & ~MASK_1);
      t = ((t >> 2) & MASK_2) | ((t << 2) & ~MASK_2);
      t = ((t >> 4) & MASK_4) | ((t << 4) & ~MASK_4);
      return t;
   endfunction

   // control store
   function automatic ctrl_word_type program_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         4'd0:    w = '{OP_WAIT,     COND_WAIT_REQ, PC_START};
         4'd1:    w = '{OP_MUL,      COND_NEXT,     PC_START};
         4'd2:    w = '{OP_ABS,      COND_NEXT,     PC_START};
         4'd3:    w = '{OP_RECIP,    COND_NEXT,     PC_START};
         4'd4:    w = '{OP_PROP,     COND_NEXT,     PC_START};
         4'd5:    w = '{OP_DIV_INIT, COND_NEXT,     PC_START};
         4'd6:    w = '{OP_DIV_STEP, COND_LOOP_DIV, PC_DIV};
         4'd7:    w = '{OP_SUM,      COND_NEXT,     PC_START};
         4'd8:    w = '{OP_OUT,      COND_DELIVER,  PC_START};
         default: w = '{OP_WAIT,     COND_WAIT_REQ, PC_START};
      endcase
      return w;
   endfunction

endpackage

/* rtl/motor_speed_controller.sv */
// Proportional speed controller with feedforward. One item per control tick carries the two
// bit-reversed encoder bytes; the block answers with one item holding the DAC magnitude, the
// direction bit and the signed drive. Items are worked one at a time by a small microcoded
// sequencer: after acceptance an item runs through one step each for the gain multiply,
// its magnitude, the reciprocal multiply for the division by ten, restoring the sign and
// loading the divider, then the restoring division loop for the feedforward term, the
// final sum and the output load. The next item can be accepted in the cycle after the
// result is loaded. req_ready is high only while the sequencer waits at its first step; a
// result held in the output register does not stop the next item from being accepted, only
// the loading of its own result, which waits for as long as the earlier result is not taken.
// Configuration must be written while no item is in flight.
`include "motor_speed_controller_assert.svh"

module motor_speed_controller
   import msc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [REF_W-1:0]         csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [BYTE_W-1:0]        req_encoder_high_raw,
   input  logic [BYTE_W-1:0]        req_encoder_low_raw,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [BYTE_W-1:0]        rsp_dac_value,
   output logic                     rsp_direction_reverse,
   output logic signed [WORD_W-1:0] rsp_drive_value
);

   logic [REF_W-1:0]  speed_ref_ff;
   logic [BYTE_W-1:0] gain_ff, divider_ff, offset_ff;

   logic [PC_W-1:0]   pc_ff, pc_in;
   ctrl_word_type     cw;

   logic [WORD_W-1:0] prev_ff, prev_in;
   logic signed [WORD_W-1:0] err_ff, err_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [MAG_W+RECIP_W-1:0] recip_ff, recip_in;
   logic [WORD_W-1:0] prop_ff, prop_in;
   logic [REF_W-1:0]  dvd_ff, dvd_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [3:0]        div_cnt_ff, div_cnt_in;
   logic [WORD_W-1:0] drive_ff, drive_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] dac_ff, dac_in;
   logic              dir_ff, dir_in;
   logic [WORD_W-1:0] out_drive_ff, out_drive_in;

   logic              accept, stall, ref_zero;
   logic [WORD_W-1:0] count, ref_ext, ff_term;
   logic [QUOT_W-1:0] quot;
   logic [REF_W-1:0]  trial;
   logic [WORD_W:0]   drive_ext, drive_mag;
   logic [WORD_W+1:0] dac_sum;

   assign cw        = program_rom(pc_ff);
   assign req_ready = (cw.op == OP_WAIT);
   assign accept    = req_valid && req_ready;
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign ref_zero  = (speed_ref_ff == '0);
   assign ref_ext   = {{(WORD_W-REF_W){speed_ref_ff[REF_W-1]}}, speed_ref_ff};
   assign count     = {reverse_byte(req_encoder_high_raw), reverse_byte(req_encoder_low_raw)};
   assign quot      = recip_ff[MAG_W+RECIP_W-1 -: QUOT_W];
   assign trial     = {rem_ff, dvd_ff[REF_W-1]};
   assign ff_term   = (divider_ff == '0) ? '0 :
                      speed_ref_ff[REF_W-1] ? (~{{(WORD_W-REF_W){1'b0}}, dvd_ff} + 16'd1) :
                      {{(WORD_W-REF_W){1'b0}}, dvd_ff};
   assign drive_ext = {drive_ff[WORD_W-1], drive_ff};
   assign drive_mag = drive_ff[WORD_W-1] ? (~drive_ext + 17'd1) : drive_ext;
   assign dac_sum   = {1'b0, drive_mag} + {{(WORD_W+2-BYTE_W){1'b0}}, offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ref_ff <= '0;
         gain_ff      <= 8'd10;
         divider_ff   <= 8'd1;
         offset_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPEED_REFERENCE:     speed_ref_ff <= csr_write_data;
            CSR_PROPORTIONAL_GAIN:   gain_ff      <= csr_write_data[BYTE_W-1:0];
            CSR_FEEDFORWARD_DIVIDER: divider_ff   <= csr_write_data[BYTE_W-1:0];
            CSR_DAC_OFFSET:          offset_ff    <= csr_write_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      pc_in        = pc_ff + 4'd1;
      prev_in      = prev_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      recip_in     = recip_ff;
      prop_in      = prop_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dac_in       = dac_ff;
      dir_in       = dir_ff;
      out_drive_in = out_drive_ff;

      unique case (cw.op)
         OP_WAIT: begin
            if (accept) begin
               prev_in = count;
               err_in  = $signed(ref_ext - count + prev_ff);
            end
         end
         OP_MUL: prod_in = $signed({{(PROD_W-BYTE_W){1'b0}}, gain_ff}) *
                           $signed({{(PROD_W-WORD_W){err_ff[WORD_W-1]}}, err_ff});
         OP_ABS: begin
            neg_in = prod_ff[PROD_W-1];
            mag_in = prod_ff[PROD_W-1] ? MAG_W'(~prod_ff + 25'sd1) : MAG_W'(prod_ff);
         end
         OP_RECIP: recip_in = {{RECIP_W{1'b0}}, mag_ff} * {{MAG_W{1'b0}}, RECIP_MULT};
         OP_PROP:  prop_in  = neg_ff ? (~quot[WORD_W-1:0] + 16'd1) : quot[WORD_W-1:0];
         OP_DIV_INIT: begin
            dvd_in     = speed_ref_ff[REF_W-1] ? (~speed_ref_ff + 9'd1) : speed_ref_ff;
            rem_in     = '0;
            div_cnt_in = 4'(DIV_STEPS);
         end
         OP_DIV_STEP: begin
            if (trial >= {1'b0, divider_ff}) begin
               rem_in = BYTE_W'(trial - {1'b0, divider_ff});
               dvd_in = {dvd_ff[REF_W-2:0], 1'b1};
            end else begin
               rem_in = trial[BYTE_W-1:0];
               dvd_in = {dvd_ff[REF_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 4'd1;
         end
         OP_SUM: drive_in = ref_zero ? '0 : (prop_ff + ff_term);
         OP_OUT: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               out_drive_in = drive_ff;
               dir_in       = drive_ff[WORD_W-1] || (drive_ff == '0);
               if (ref_zero) begin
                  dac_in = '0;
               end else if (dac_sum[WORD_W+1:BYTE_W] != '0) begin
                  dac_in = DAC_MAX;
               end else begin
                  dac_in = dac_sum[BYTE_W-1:0];
               end
            end
         end
         default: ;
      endcase

      unique case (cw.cond)
         COND_NEXT:     pc_in = pc_ff + 4'd1;
         COND_WAIT_REQ: pc_in = accept ? (pc_ff + 4'd1) : pc_ff;
         COND_LOOP_DIV: pc_in = (div_cnt_ff != 4'd1) ? cw.target : (pc_ff + 4'd1);
         COND_DELIVER:  pc_in = stall ? pc_ff : cw.target;
         default:       pc_in = PC_START;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_START;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         pc_ff        <= pc_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      recip_ff     <= recip_in;
      prop_ff      <= prop_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      drive_ff     <= drive_in;
      dac_ff       <= dac_in;
      dir_ff       <= dir_in;
      out_drive_ff <= out_drive_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dac_value         = dac_ff;
   assign rsp_direction_reverse = dir_ff;
   assign rsp_drive_value       = $signed(out_drive_ff);

   `MSC_ASSERT_NEXT(a_one_item_at_a_time, accept, !req_ready, "item accepted while busy")
   `MSC_ASSERT_ALWAYS(a_pc_in_program, pc_ff <= PC_LAST, "step counter outside program")
   `MSC_ASSERT_IMPLY(a_forward_means_positive, rsp_valid && !rsp_direction_reverse,
      !rsp_drive_value[WORD_W-1] && (rsp_drive_value != '0), "forward with non-positive drive")

endmodule
